FILE: sv/clint_pkg.sv
`timescale 1ns / 1ps

package clint_pkg;

	// Bus function codes.
	typedef enum logic [1:0] {
		FUNC_READ   = 2'd0,
		FUNC_WRITE  = 2'd1,
		FUNC_TICK   = 2'd2,
		FUNC_ATOMIC = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_WIDTH  = 3'd1,
		ST_MISALIGNED = 3'd2,
		ST_NO_REG     = 3'd3,
		ST_ATOMIC     = 3'd4
	} status_t;

	// Which part of a 64-bit timer register an access selects.
	typedef enum logic [1:0] {
		HIT_NONE,
		HIT_FULL,
		HIT_LOW,
		HIT_HIGH
	} hit_t;

	// Access size codes (log2 of bytes).
	localparam logic [1:0] WIDTH_WORD  = 2'd2;
	localparam logic [1:0] WIDTH_DWORD = 2'd3;

	// Default register map.
	localparam logic [15:0] MSIP_OFFSET_DEF    = 16'd0;
	localparam logic [15:0] COMPARE_OFFSET_DEF = 16'd16384;
	localparam logic [15:0] TIME_OFFSET_DEF    = 16'd49144;

	// One request item as held in the input register.
	typedef struct packed {
		func_t       func;
		logic [15:0] offset;
		logic [1:0]  width;
		logic [63:0] write_data;
		logic [63:0] tick_count;
	} req_t;

	// Result of the core stage, before the timer compare.
	typedef struct packed {
		status_t     status;
		logic [63:0] read_data;
		logic        software_irq;
		logic [63:0] time_now;
		logic [63:0] compare;
	} core_res_t;

	// Decode an access against a 64-bit timer register at base.
	function automatic hit_t timer_hit(logic [15:0] off, logic [1:0] w, logic [15:0] base);
		logic [16:0] base_hi;
		base_hi = {1'b0, base} + 17'd4;
		timer_hit = HIT_NONE;
		if (w == WIDTH_DWORD && off == base) begin
			timer_hit = HIT_FULL;
		end else if (w == WIDTH_WORD) begin
			if (off == base) begin
				timer_hit = HIT_LOW;
			end else if ({1'b0, off} == base_hi) begin
				timer_hit = HIT_HIGH;
			end
		end
	endfunction

	// Read the selected part, zero-extended.
	function automatic logic [63:0] timer_read(logic [63:0] r, hit_t hit);
		unique case (hit)
			HIT_FULL: timer_read = r;
			HIT_LOW:  timer_read = {32'd0, r[31:0]};
			default:  timer_read = {32'd0, r[63:32]};
		endcase
	endfunction

	// Merge write data into the selected part.
	function automatic logic [63:0] timer_write(logic [63:0] r, hit_t hit, logic [63:0] v);
		unique case (hit)
			HIT_FULL: timer_write = v;
			HIT_LOW:  timer_write = {r[63:32], v[31:0]};
			default:  timer_write = {v[31:0], r[31:0]};
		endcase
	endfunction

endpackage

FILE: sv/clint_req_if.sv
`timescale 1ns / 1ps

interface clint_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] offset;
	logic [1:0]  width;
	logic [63:0] write_data;
	logic [63:0] tick_count;

	modport source (output valid, func, offset, width, write_data, tick_count, input ready);
	modport sink (input valid, func, offset, width, write_data, tick_count, output ready);
endinterface

FILE: sv/clint_rsp_if.sv
`timescale 1ns / 1ps

interface clint_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] read_data;
	logic        software_irq;
	logic        timer_irq;
	logic [63:0] time_now;

	modport source (output valid, status, read_data, software_irq, timer_irq, time_now,
		input ready);
	modport sink (input valid, status, read_data, software_irq, timer_irq, time_now,
		output ready);
endinterface

FILE: sv/clint_core.sv
`timescale 1ns / 1ps

module clint_core #(
	parameter logic [15:0] MSIP_OFFSET    = clint_pkg::MSIP_OFFSET_DEF,
	parameter logic [15:0] COMPARE_OFFSET = clint_pkg::COMPARE_OFFSET_DEF,
	parameter logic [15:0] TIME_OFFSET    = clint_pkg::TIME_OFFSET_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  clint_pkg::req_t       item,
	input  logic                  fire,
	output clint_pkg::core_res_t  res
);
	import clint_pkg::*;

	logic        soft_q;
	logic [63:0] cmp_q;
	logic [63:0] time_q;

	logic        soft_d;
	logic [63:0] cmp_d;
	logic [63:0] time_d;
	status_t     status;
	logic [63:0] rdata;
	hit_t        hc;
	hit_t        ht;
	logic        msip_hit;
	logic        wr;
	logic        misaligned;

	// Register decode for the item in the input register.
	always_comb begin
		hc         = timer_hit(item.offset, item.width, COMPARE_OFFSET);
		ht         = timer_hit(item.offset, item.width, TIME_OFFSET);
		msip_hit   = (item.width == WIDTH_WORD) && (item.offset == MSIP_OFFSET);
		wr         = (item.func == FUNC_WRITE);
		misaligned = (item.width == WIDTH_DWORD) ? (item.offset[2:0] != 3'd0)
			: (item.offset[1:0] != 2'd0);
	end

	// Next state and result; order: atomic, tick, width, alignment, decode.
	always_comb begin
		status = ST_OK;
		rdata  = '0;
		soft_d = soft_q;
		cmp_d  = cmp_q;
		time_d = time_q;
		priority if (item.func == FUNC_ATOMIC) begin
			status = ST_ATOMIC;
		end else if (item.func == FUNC_TICK) begin
			time_d = time_q + item.tick_count;
		end else if (item.width != WIDTH_WORD && item.width != WIDTH_DWORD) begin
			status = ST_BAD_WIDTH;
		end else if (misaligned) begin
			status = ST_MISALIGNED;
		end else if (msip_hit) begin
			if (wr) begin
				soft_d = item.write_data[0];
			end else begin
				rdata = {63'd0, soft_q};
			end
		end else if (hc != HIT_NONE) begin
			if (wr) begin
				cmp_d = timer_write(cmp_q, hc, item.write_data);
			end else begin
				rdata = timer_read(cmp_q, hc);
			end
		end else if (ht != HIT_NONE) begin
			if (wr) begin
				time_d = timer_write(time_q, ht, item.write_data);
			end else begin
				rdata = timer_read(time_q, ht);
			end
		end else begin
			status = ST_NO_REG;
		end
	end

	// Architectural state, updated as the item moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_q <= 1'b0;
			cmp_q  <= '1;
			time_q <= '0;
		end else if (fire) begin
			soft_q <= soft_d;
			cmp_q  <= cmp_d;
			time_q <= time_d;
		end
	end

	assign res.status       = status;
	assign res.read_data    = rdata;
	assign res.software_irq = soft_d;
	assign res.time_now     = time_d;
	assign res.compare      = cmp_d;
endmodule

FILE: sv/clint_out.sv
`timescale 1ns / 1ps

module clint_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  clint_pkg::core_res_t in_res,
	clint_rsp_if.source          rsp
);
	import clint_pkg::*;

	logic        v_s2;
	core_res_t   res_s2;
	logic        v_s3;
	logic [2:0]  status_s3;
	logic [63:0] rdata_s3;
	logic        soft_s3;
	logic        timer_s3;
	logic [63:0] time_s3;
	logic        rdy_s3;

	// A stage takes a new item when empty or when its item leaves.
	assign rdy_s3   = !v_s3 || rsp.ready;
	assign in_ready = !v_s2 || rdy_s3;

	// Valid flags for the result stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Result payload; the timer compare sits between the two stages.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_s2 <= in_res;
		end
		if (rdy_s3 && v_s2) begin
			status_s3 <= res_s2.status;
			rdata_s3  <= res_s2.read_data;
			soft_s3   <= res_s2.software_irq;
			timer_s3  <= (res_s2.time_now >= res_s2.compare);
			time_s3   <= res_s2.time_now;
		end
	end

	assign rsp.valid        = v_s3;
	assign rsp.status       = status_s3;
	assign rsp.read_data    = rdata_s3;
	assign rsp.software_irq = soft_s3;
	assign rsp.timer_irq    = timer_s3;
	assign rsp.time_now     = time_s3;
endmodule

FILE: sv/core_local_timer_interrupter.sv
`timescale 1ns / 1ps
// Single-hart core-local timer and software interrupt block.
// An accepted item moves through the input register and the result register into
// the output register, which presents its result until it is taken.
// Throughput: one item per cycle unless the response side stalls; the 64-bit
// time add and the state update share one stage, the timer compare its own.
// Reset clears msip and mtime, sets mtimecmp to all ones and empties the pipeline.

module core_local_timer_interrupter #(
	parameter logic [15:0] MSIP_OFFSET    = clint_pkg::MSIP_OFFSET_DEF,
	parameter logic [15:0] COMPARE_OFFSET = clint_pkg::COMPARE_OFFSET_DEF,
	parameter logic [15:0] TIME_OFFSET    = clint_pkg::TIME_OFFSET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	clint_req_if.sink   req,
	clint_rsp_if.source rsp
);
	import clint_pkg::*;

	logic      v_s1;
	req_t      item_s1;
	logic      rdy_s2;
	logic      fire;
	core_res_t core_res;

	// The input register frees up when its item moves into the result stage.
	assign req.ready = !v_s1 || rdy_s2;
	assign fire      = v_s1 && rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	// Input item register.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.func       <= func_t'(req.func);
			item_s1.offset     <= req.offset;
			item_s1.width      <= req.width;
			item_s1.write_data <= req.write_data;
			item_s1.tick_count <= req.tick_count;
		end
	end

	clint_core #(
		.MSIP_OFFSET    (MSIP_OFFSET),
		.COMPARE_OFFSET (COMPARE_OFFSET),
		.TIME_OFFSET    (TIME_OFFSET)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (fire),
		.res    (core_res)
	);

	clint_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_ready (rdy_s2),
		.in_res   (core_res),
		.rsp      (rsp)
	);
endmodule
